// ----- sv/assert_macros.svh -----
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked while out of reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- sv/itp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package itp_pkg;

  localparam int unsigned STACK_DEPTH = 3;
  localparam int unsigned CHAR_W      = 8;

  localparam logic [CHAR_W-1:0] CH_ONE  = 8'h31;  // '1'
  localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CH_MUL  = 8'h2A;  // '*'
  localparam logic [CHAR_W-1:0] CH_DIV  = 8'h2F;  // '/'

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [1:0]        rank_t;
  typedef logic [1:0]        count_t;

  localparam rank_t RANK_DIGIT = 2'd3;
  localparam rank_t RANK_MULDIV = 2'd2;
  localparam rank_t RANK_OTHER = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_FLUSH
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture the input transaction
    logic pop;        // pop the top entry into the output register
    logic push;       // push the current character
    logic run_last;   // popped entry is the last result of this item
    logic expr_last;  // popped entry ends the postfix expression
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic   top_ge;    // top entry ranks at least the current character
    logic   next_ge;   // entry below the top ranks at least the current one
    count_t count;     // stack fill
    logic   fin;       // current character closes the expression
    logic   out_free;  // output register can take a result this cycle
  } dp_stat_t;

  // Priority of a character
  function automatic rank_t rank_of(input char_t ch);
    if (ch >= CH_ONE && ch <= CH_NINE) begin
      return RANK_DIGIT;
    end else if (ch == CH_MUL || ch == CH_DIV) begin
      return RANK_MULDIV;
    end else begin
      return RANK_OTHER;
    end
  endfunction

endpackage
`default_nettype wire

// ----- sv/itp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module itp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire itp_pkg::dp_stat_t stat,
  output itp_pkg::dp_cmd_t      cmd
);
  import itp_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequence pops, the push and the final flush
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        if (stat.top_ge) begin
          // Pop only when the output register has room
          if (stat.out_free) begin
            cmd.pop      = 1'b1;
            cmd.run_last = !stat.fin && !stat.next_ge;
          end
        end else begin
          cmd.push  = 1'b1;
          state_nxt = stat.fin ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (stat.out_free) begin
          cmd.pop       = 1'b1;
          cmd.run_last  = (stat.count == 2'd1);
          cmd.expr_last = (stat.count == 2'd1);
          if (stat.count == 2'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/itp_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module itp_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        in_tdata,   // [7:0] in_char
  input  wire logic              in_tlast,   // is_final
  input  wire itp_pkg::dp_cmd_t  cmd,
  output itp_pkg::dp_stat_t      stat,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [7:0]             out_tdata,  // [7:0] out_char
  output logic                   out_tlast,  // run_last
  output logic                   out_tuser   // expr_last
);
  import itp_pkg::*;

  char_t  cur_r;
  logic   fin_r;
  rank_t  cur_rank;
  char_t  stk_r [STACK_DEPTH];  // entry 0 is the top
  count_t count_r;
  logic   out_valid_r;
  char_t  out_char_r;
  logic   out_run_last_r;
  logic   out_expr_last_r;

  assign cur_rank = rank_of(cur_r);

  // Report to the controller
  always_comb begin
    stat.top_ge   = (count_r != 2'd0) && (rank_of(stk_r[0]) >= cur_rank);
    stat.next_ge  = (count_r > 2'd1) && (rank_of(stk_r[1]) >= cur_rank);
    stat.count    = count_r;
    stat.fin      = fin_r;
    stat.out_free = !out_valid_r || out_tready;
  end

  // Capture the incoming character
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r <= in_tdata;
      fin_r <= in_tlast;
    end
  end

  // Shift the stack down on push, up on pop
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stk_r[0] <= cur_r;
      stk_r[1] <= stk_r[0];
      stk_r[2] <= stk_r[1];
    end else if (cmd.pop) begin
      stk_r[0] <= stk_r[1];
      stk_r[1] <= stk_r[2];
    end
  end

  // Track the fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.push && count_r != count_t'(STACK_DEPTH)) begin
      count_r <= count_r + 2'd1;
    end else if (cmd.pop) begin
      count_r <= count_r - 2'd1;
    end
  end

  // Output register: load on pop, drop once the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      out_char_r      <= stk_r[0];
      out_run_last_r  <= cmd.run_last;
      out_expr_last_r <= cmd.expr_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_run_last_r;
  assign out_tuser  = out_expr_last_r;

endmodule
`default_nettype wire

// ----- sv/infix_to_postfix_converter.sv -----
// Sequence: a character is taken in, the stack entries that rank at least as high are popped
// one at a time, the character is pushed, and on a final character the stack is flushed entry by
// entry; each result shows in the cycle after its pop, and pops wait while the output is full.
// Flow: one character at a time; the next is accepted only once the last is pushed (and flushed, if final).
// Reset: synchronous, active-low rst_n empties the stack and clears the output valid.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module infix_to_postfix_converter (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_char
  input  wire logic       in_tlast,   // is_final
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_char
  output logic            out_tlast,  // run_last
  output logic            out_tuser   // expr_last
);
  import itp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  itp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  itp_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // A pop never overwrites a result that is still waiting
  `ASSERT_IMPL(a_pop_has_room, clk, rst_n, cmd.pop, stat.out_free)
  // The stack never overflows on a push
  `ASSERT_IMPL(a_push_fits, clk, rst_n, cmd.push, stat.count != 2'd3)
  // The end of an expression leaves the stack empty
  `ASSERT_NEXT(a_flush_empties, clk, rst_n, cmd.pop && cmd.expr_last, stat.count == 2'd0)

endmodule
`default_nettype wire

// ----- verif/infix_to_postfix_converter_tb.sv -----
`timescale 1ns / 1ps
module infix_to_postfix_converter_tb;
  import itp_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 320;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned HOLDOFF_LEN   = 300;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned MAX_REPORTS   = 10;

  localparam char_t CH_ZERO  = 8'h30;  // '0'
  localparam char_t CH_PLUS  = 8'h2B;  // '+'
  localparam char_t CH_MINUS = 8'h2D;  // '-'

  // Postfix predictor: its own operator stack and the queue of expected output characters
  class postfix_scoreboard;
    typedef struct packed {
      char_t ch;
      logic  run_last;
      logic  expr_last;
    } postfix_out_t;

    char_t        held_ops[STACK_DEPTH];
    int unsigned  held;
    postfix_out_t postfix_q[$];
    int unsigned  errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    function int unsigned char_priority(input char_t ch);
      if (ch >= CH_ONE && ch <= CH_NINE) begin
        return 3;
      end else if (ch == CH_MUL || ch == CH_DIV) begin
        return 2;
      end
      return 1;
    endfunction

    function int unsigned pending();
      return postfix_q.size();
    endfunction

    // Pop what ranks at least as high as the new character, push it, flush on the final one
    function void note_char(input char_t ch, input logic fin);
      postfix_out_t batch[$];
      int unsigned  prio;
      int           last_idx;
      prio = char_priority(ch);
      while (held > 0 && char_priority(held_ops[held-1]) >= prio) begin
        batch.push_back('{ch: held_ops[held-1], run_last: 1'b0, expr_last: 1'b0});
        held--;
      end
      held_ops[held] = ch;
      held++;
      if (fin) begin
        while (held > 0) begin
          batch.push_back('{ch: held_ops[held-1], run_last: 1'b0, expr_last: 1'b0});
          held--;
        end
      end
      if (batch.size() > 0) begin
        last_idx = batch.size() - 1;
        batch[last_idx].run_last  = 1'b1;
        batch[last_idx].expr_last = fin;
      end
      foreach (batch[i]) postfix_q.push_back(batch[i]);
    endfunction

    // Compare one output transaction against the oldest expected character
    function void check_result(input char_t ch, input logic rl, input logic el);
      postfix_out_t want;
      if (postfix_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected output char=%h run_last=%b expr_last=%b",
                   $realtime, ch, rl, el);
        return;
      end
      want = postfix_q.pop_front();
      if (want.ch !== ch || want.run_last !== rl || want.expr_last !== el) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: mismatch expected char=%h run_last=%b expr_last=%b, got char=%h run_last=%b expr_last=%b",
                   $realtime, want.ch, want.run_last, want.expr_last, ch, rl, el);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] in_char
  logic        in_tlast = 1'b0;    // is_final
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;          // [7:0] out_char
  logic        out_tlast;          // run_last
  logic        out_tuser;          // expr_last

  logic        rx_hold = 1'b0;
  logic [1:0]  ready_mode = 2'd0;
  logic [5:0]  mode_cycles = 6'd0;
  int unsigned idle_cycles = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;

  postfix_scoreboard sb = new();

  infix_to_postfix_converter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Record accepted characters and check accepted output transactions
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_char(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast, out_tuser);
    end
  end

  // Receiver stall pattern; a new mode is drawn each time mode_cycles wraps
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready  <= 1'b0;
      ready_mode  <= 2'd0;
      mode_cycles <= 6'd0;
    end else begin
      mode_cycles <= mode_cycles + 6'd1;
      if (mode_cycles == 6'd63) ready_mode <= 2'($urandom_range(0, 3));
      if (rx_hold) begin
        out_tready <= 1'b0;
      end else begin
        case (ready_mode)
          2'd0: out_tready <= 1'b1;
          2'd1: out_tready <= 1'($urandom_range(0, 1));
          2'd2: out_tready <= (mode_cycles[2:0] != 3'd0);
          default: out_tready <= mode_cycles[1];
        endcase
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("infix_to_postfix_converter regression: fail");
        $finish;
      end
    end
  end

  // Offer one character; bursts of random length separated by random gaps
  task automatic send_char(input char_t ch, input logic fin);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Hold the receiver off while the sender keeps going
  task automatic rx_holdoff(input int unsigned cycles);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold <= 1'b0;
  endtask

  // Stop offering until every expected character has come out
  task automatic drain_pause();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic char_t pick_operand();
    return CH_ZERO + char_t'($urandom_range(0, 9));
  endfunction

  function automatic char_t pick_operator();
    case ($urandom_range(0, 3))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_MUL;
      default: return CH_DIV;
    endcase
  endfunction

  // Well-formed expression: operands and operators alternate, final on the last operand
  task automatic send_expression();
    int unsigned n_operands;
    n_operands = $urandom_range(1, 5);
    for (int unsigned k = 0; k < n_operands; k++) begin
      send_char(pick_operand(), k == n_operands - 1);
      if (k != n_operands - 1) send_char(pick_operator(), 1'b0);
    end
  endtask

  // Broken sequence: random bytes, stray finals, always closed by a final byte
  task automatic send_noise();
    int unsigned len;
    char_t       ch;
    len = $urandom_range(1, 6);
    for (int unsigned k = 0; k < len; k++) begin
      case ($urandom_range(0, 2))
        0: ch = pick_operand();
        1: ch = pick_operator();
        default: ch = char_t'($urandom_range(0, 255));
      endcase
      send_char(ch, (k == len - 1) || ($urandom_range(0, 3) == 0));
    end
  endtask

  initial begin
    int unsigned random_target;
    bit          holdoff_done;
    bit          pause_done;
    holdoff_done = 1'b0;
    pause_done   = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Mixed precedence: 1+2*3
    send_char(CH_ONE, 1'b0);
    send_char(CH_PLUS, 1'b0);
    send_char(8'h32, 1'b0);
    send_char(CH_MUL, 1'b0);
    send_char(8'h33, 1'b1);
    // Equal ranks pop left to right: 8/4/2
    send_char(8'h38, 1'b0);
    send_char(CH_DIV, 1'b0);
    send_char(8'h34, 1'b0);
    send_char(CH_DIV, 1'b0);
    send_char(8'h32, 1'b1);
    // Single low-rank character as a whole expression
    send_char(CH_ZERO, 1'b1);
    // Two digits in a row
    send_char(8'h35, 1'b0);
    send_char(8'h37, 1'b1);
    // Byte extremes and non-printable bytes mixed with every rank
    send_char(8'h00, 1'b0);
    send_char(CH_ONE, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CH_NINE, 1'b0);
    send_char(CH_MUL, 1'b0);
    send_char(CH_DIV, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(CH_ZERO, 1'b1);

    // Random expressions with some noise; pressure applied along the way
    random_target = items_sent + RANDOM_ITEMS;
    while (items_sent < random_target) begin
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_expression();
      if (!holdoff_done && items_sent >= 100) begin
        holdoff_done = 1'b1;
        fork
          rx_holdoff(HOLDOFF_LEN);
        join_none
      end
      if (!pause_done && items_sent >= 220) begin
        pause_done = 1'b1;
        drain_pause();
      end
    end
    send_expression();
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("infix_to_postfix_converter regression: pass");
    end else begin
      $display("infix_to_postfix_converter regression: fail");
    end
    $finish;
  end

endmodule
